// ----- hw/rtl/dtc_pkg.sv -----
`default_nettype none
package dtc_pkg;

   localparam int DTC_DEST_ENTRIES = 64;
   localparam int DTC_COUNT_WIDTH  = 32;

   localparam logic [7:0] PROTO_NUM_TCP  = 8'd6;
   localparam logic [7:0] PROTO_NUM_UDP  = 8'd17;
   localparam logic [7:0] PROTO_NUM_ICMP = 8'd1;

   localparam logic [1:0] CLASS_TCP   = 2'd0;
   localparam logic [1:0] CLASS_UDP   = 2'd1;
   localparam logic [1:0] CLASS_ICMP  = 2'd2;
   localparam logic [1:0] CLASS_OTHER = 2'd3;

   typedef struct packed {
      logic        valid;
      logic        stored;
      logic [5:0]  slot;
      logic [31:0] hits;
      logic [31:0] addr;
      logic [1:0]  cls;
      logic [31:0] class_hits;
      logic [31:0] packets;
      logic [31:0] bytes;
   } token_type;

endpackage
`default_nettype wire

// ----- hw/rtl/dtc_stats.sv -----
`default_nettype none
module dtc_stats
   import dtc_pkg::*;
#(
   parameter int COUNT_WIDTH = DTC_COUNT_WIDTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        accept,
   input  wire logic [31:0] dest_addr,
   input  wire logic [7:0]  ip_protocol,
   input  wire logic [15:0] frame_len,
   output token_type        tok_out
);

   logic [COUNT_WIDTH-1:0] packets_ff, packets_in;
   logic [31:0]            bytes_ff, bytes_in;
   logic [COUNT_WIDTH-1:0] class_ff [4];
   logic [COUNT_WIDTH-1:0] class_sel_in;
   logic [1:0]             cls;
   token_type              tok_ff, tok_in;

   always_comb begin
      priority if (ip_protocol == PROTO_NUM_TCP) begin
         cls = CLASS_TCP;
      end else if (ip_protocol == PROTO_NUM_UDP) begin
         cls = CLASS_UDP;
      end else if (ip_protocol == PROTO_NUM_ICMP) begin
         cls = CLASS_ICMP;
      end else begin
         cls = CLASS_OTHER;
      end
   end

   always_comb begin
      packets_in   = (packets_ff == '1) ? packets_ff : COUNT_WIDTH'(packets_ff + 1'b1);
      bytes_in     = bytes_ff + 32'(frame_len);
      class_sel_in = (class_ff[cls] == '1) ? class_ff[cls]
                                           : COUNT_WIDTH'(class_ff[cls] + 1'b1);
      tok_in.valid      = accept;
      tok_in.stored     = 1'b0;
      tok_in.slot       = '0;
      tok_in.hits       = '0;
      tok_in.addr       = dest_addr;
      tok_in.cls        = cls;
      tok_in.class_hits = 32'(class_sel_in);
      tok_in.packets    = 32'(packets_in);
      tok_in.bytes      = bytes_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         packets_ff   <= '0;
         bytes_ff     <= '0;
         class_ff[0]  <= '0;
         class_ff[1]  <= '0;
         class_ff[2]  <= '0;
         class_ff[3]  <= '0;
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff <= tok_in;
         if (accept) begin
            packets_ff    <= packets_in;
            bytes_ff      <= bytes_in;
            class_ff[cls] <= class_sel_in;
         end
      end
   end

   assign tok_out = tok_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/dtc_cell.sv -----
`default_nettype none
module dtc_cell
   import dtc_pkg::*;
#(
   parameter int COUNT_WIDTH = DTC_COUNT_WIDTH,
   parameter int CELL_INDEX  = 0
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire token_type tok_in_prev,
   output      token_type tok_out
);

   localparam logic [5:0] SLOT_CODE = 6'(CELL_INDEX);

   logic                   valid_ff, valid_in;
   logic [31:0]            addr_ff, addr_in;
   logic [COUNT_WIDTH-1:0] hits_ff, hits_in;
   token_type              tok_ff, tok_in;

   always_comb begin
      valid_in = valid_ff;
      addr_in  = addr_ff;
      hits_in  = hits_ff;
      tok_in   = tok_in_prev;
      if (tok_in_prev.valid && !tok_in_prev.stored) begin
         if (valid_ff && (addr_ff == tok_in_prev.addr)) begin
            hits_in       = (hits_ff == '1) ? hits_ff : COUNT_WIDTH'(hits_ff + 1'b1);
            tok_in.stored = 1'b1;
            tok_in.slot   = SLOT_CODE;
            tok_in.hits   = 32'(hits_in);
         end else if (!valid_ff) begin
            valid_in      = 1'b1;
            addr_in       = tok_in_prev.addr;
            hits_in       = COUNT_WIDTH'(1);
            tok_in.stored = 1'b1;
            tok_in.slot   = SLOT_CODE;
            tok_in.hits   = 32'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         tok_ff.valid <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         tok_ff   <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      hits_ff <= hits_in;
   end

   assign tok_out = tok_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/destination_traffic_counter_unit.sv -----
// Per-destination traffic counter. A beat is taken whenever start is high and busy is low.
// Busy is a registered copy of reset, so once it is low again a beat can be
// taken in every cycle. Each beat walks a row of DEST_ENTRIES cells, one cell per cycle.
// Its result is registered in the stats stage and in each cell, and is on the rsp_ ports
// for exactly one cycle with rsp_valid high. The receiver cannot stall, and results leave
// in the order the beats came in. A new destination is stored in the first free cell.
// Once all cells are in use, new destinations are reported with rsp_dest_stored low while
// the totals still count them.
`default_nettype none
module destination_traffic_counter_unit
   import dtc_pkg::*;
#(
   parameter int DEST_ENTRIES = DTC_DEST_ENTRIES,
   parameter int COUNT_WIDTH  = DTC_COUNT_WIDTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output      logic        busy,
   input  wire logic [31:0] req_dest_addr,
   input  wire logic [7:0]  req_ip_protocol,
   input  wire logic [15:0] req_frame_len,
   output      logic        rsp_valid,
   output      logic [31:0] rsp_dest_hits,
   output      logic [5:0]  rsp_dest_slot,
   output      logic        rsp_dest_stored,
   output      logic [1:0]  rsp_proto_class,
   output      logic [31:0] rsp_class_hits,
   output      logic [31:0] rsp_packets_total,
   output      logic [31:0] rsp_bytes_total
);

   logic      busy_ff;
   logic      accept;
   token_type chain [DEST_ENTRIES+1];

   always_ff @(posedge clock) begin
      busy_ff <= reset;
   end

   assign busy   = busy_ff;
   assign accept = start && !busy_ff;

   dtc_stats #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_stats (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .dest_addr  (req_dest_addr),
      .ip_protocol(req_ip_protocol),
      .frame_len  (req_frame_len),
      .tok_out    (chain[0])
   );

   for (genvar i = 0; i < DEST_ENTRIES; i++) begin : g_cell
      dtc_cell #(
         .COUNT_WIDTH(COUNT_WIDTH),
         .CELL_INDEX (i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .tok_in_prev(chain[i]),
         .tok_out    (chain[i+1])
      );
   end

   assign rsp_valid         = chain[DEST_ENTRIES].valid;
   assign rsp_dest_hits     = chain[DEST_ENTRIES].hits;
   assign rsp_dest_slot     = chain[DEST_ENTRIES].slot;
   assign rsp_dest_stored   = chain[DEST_ENTRIES].stored;
   assign rsp_proto_class   = chain[DEST_ENTRIES].cls;
   assign rsp_class_hits    = chain[DEST_ENTRIES].class_hits;
   assign rsp_packets_total = chain[DEST_ENTRIES].packets;
   assign rsp_bytes_total   = chain[DEST_ENTRIES].bytes;

   a_unstored_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_dest_stored |-> rsp_dest_hits == 32'd0 && rsp_dest_slot == 6'd0)
      else $error("unstored destination reports nonzero hits or slot");

   a_stored_hits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dest_stored |-> rsp_dest_hits != 32'd0)
      else $error("stored destination reports zero hits");

   a_packets_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_packets_total != 32'd0 && rsp_class_hits != 32'd0)
      else $error("result reports a zero packet or class count");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      accept |=> chain[0].valid)
      else $error("taken beat did not enter the cell row");

endmodule
`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
module tb
   import dtc_pkg::*;
();

   localparam int RANDOM_PER_PHASE = 345;
   localparam int ADDR_POOL_SIZE   = 96;
   localparam int MAX_GAP          = 20;
   localparam int RECENT_DEPTH     = 4;

   typedef struct {
      logic [31:0] dest_hits;
      logic [5:0]  dest_slot;
      logic        dest_stored;
      logic [1:0]  proto_class;
      logic [31:0] class_hits;
      logic [31:0] packets_total;
      logic [31:0] bytes_total;
   } dest_report_type;

   class traffic_scoreboard_type;
      logic [31:0]                dest_addr_tab [DTC_DEST_ENTRIES];
      logic [DTC_COUNT_WIDTH-1:0] dest_hits_tab [DTC_DEST_ENTRIES];
      bit                         dest_in_use   [DTC_DEST_ENTRIES];
      int                         slots_filled;
      logic [DTC_COUNT_WIDTH-1:0] class_count   [4];
      logic [DTC_COUNT_WIDTH-1:0] pkts_seen;
      logic [31:0]                byte_count;
      dest_report_type            expected_reports [$];
      int                         errors;
      int                         known_hits;
      int                         new_slots;
      int                         table_full_hits;

      function new();
         slots_filled    = 0;
         pkts_seen       = '0;
         byte_count      = '0;
         errors          = 0;
         known_hits      = 0;
         new_slots       = 0;
         table_full_hits = 0;
         for (int i = 0; i < DTC_DEST_ENTRIES; i++) begin
            dest_in_use[i]   = 1'b0;
            dest_addr_tab[i] = '0;
            dest_hits_tab[i] = '0;
         end
         for (int c = 0; c < 4; c++) begin
            class_count[c] = '0;
         end
      endfunction

      function logic [DTC_COUNT_WIDTH-1:0] bump(input logic [DTC_COUNT_WIDTH-1:0] v);
         return (&v) ? v : v + 1'b1;
      endfunction

      function void note_packet(input logic [31:0] addr, input logic [7:0] proto,
                                input logic [15:0] flen);
         dest_report_type rep;
         int              slot;
         bit              found;
         slot  = 0;
         found = 1'b0;
         pkts_seen  = bump(pkts_seen);
         byte_count = byte_count + {16'd0, flen};
         for (int i = 0; i < DTC_DEST_ENTRIES; i++) begin
            if (!found && dest_in_use[i] && dest_addr_tab[i] == addr) begin
               slot  = i;
               found = 1'b1;
            end
         end
         if (found) begin
            dest_hits_tab[slot] = bump(dest_hits_tab[slot]);
            rep.dest_hits       = dest_hits_tab[slot][31:0];
            rep.dest_stored     = 1'b1;
            known_hits++;
         end else if (slots_filled < DTC_DEST_ENTRIES) begin
            slot                = slots_filled;
            dest_addr_tab[slot] = addr;
            dest_hits_tab[slot] = DTC_COUNT_WIDTH'(1);
            dest_in_use[slot]   = 1'b1;
            slots_filled++;
            rep.dest_hits       = 32'd1;
            rep.dest_stored     = 1'b1;
            new_slots++;
         end else begin
            slot            = 0;
            rep.dest_hits   = 32'd0;
            rep.dest_stored = 1'b0;
            table_full_hits++;
         end
         rep.dest_slot = slot[5:0];
         case (proto)
            PROTO_NUM_TCP:  rep.proto_class = CLASS_TCP;
            PROTO_NUM_UDP:  rep.proto_class = CLASS_UDP;
            PROTO_NUM_ICMP: rep.proto_class = CLASS_ICMP;
            default:        rep.proto_class = CLASS_OTHER;
         endcase
         class_count[rep.proto_class] = bump(class_count[rep.proto_class]);
         rep.class_hits    = class_count[rep.proto_class][31:0];
         rep.packets_total = pkts_seen[31:0];
         rep.bytes_total   = byte_count;
         expected_reports = {expected_reports, rep};
      endfunction

      function void compare_field(input string field, input logic [31:0] want,
                                  input logic [31:0] got);
         if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
            errors++;
         end
      endfunction

      function void check_report(input dest_report_type got);
         dest_report_type want;
         if (expected_reports.size() == 0) begin
            $error("Result beat arrived with no packet outstanding.");
            errors++;
            return;
         end
         want = expected_reports.pop_front();
         compare_field("dest_hits", want.dest_hits, got.dest_hits);
         compare_field("dest_slot", {26'd0, want.dest_slot}, {26'd0, got.dest_slot});
         compare_field("dest_stored", {31'd0, want.dest_stored}, {31'd0, got.dest_stored});
         compare_field("proto_class", {30'd0, want.proto_class}, {30'd0, got.proto_class});
         compare_field("class_hits", want.class_hits, got.class_hits);
         compare_field("packets_total", want.packets_total, got.packets_total);
         compare_field("bytes_total", want.bytes_total, got.bytes_total);
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [31:0] req_dest_addr;
   logic [7:0]  req_ip_protocol;
   logic [15:0] req_frame_len;
   logic        rsp_valid;
   logic [31:0] rsp_dest_hits;
   logic [5:0]  rsp_dest_slot;
   logic        rsp_dest_stored;
   logic [1:0]  rsp_proto_class;
   logic [31:0] rsp_class_hits;
   logic [31:0] rsp_packets_total;
   logic [31:0] rsp_bytes_total;

   traffic_scoreboard_type traffic_sb = new();

   destination_traffic_counter_unit u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_dest_addr     (req_dest_addr),
      .req_ip_protocol   (req_ip_protocol),
      .req_frame_len     (req_frame_len),
      .rsp_valid         (rsp_valid),
      .rsp_dest_hits     (rsp_dest_hits),
      .rsp_dest_slot     (rsp_dest_slot),
      .rsp_dest_stored   (rsp_dest_stored),
      .rsp_proto_class   (rsp_proto_class),
      .rsp_class_hits    (rsp_class_hits),
      .rsp_packets_total (rsp_packets_total),
      .rsp_bytes_total   (rsp_bytes_total)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Timed out with %0d results still outstanding.",
               traffic_sb.expected_reports.size());
      $display("destination_traffic_counter_unit test failed");
      $finish;
   end

   always @(posedge clock) begin
      dest_report_type got;
      if (!reset) begin
         if (rsp_valid === 1'b1) begin
            got.dest_hits     = rsp_dest_hits;
            got.dest_slot     = rsp_dest_slot;
            got.dest_stored   = rsp_dest_stored;
            got.proto_class   = rsp_proto_class;
            got.class_hits    = rsp_class_hits;
            got.packets_total = rsp_packets_total;
            got.bytes_total   = rsp_bytes_total;
            traffic_sb.check_report(got);
         end
         if (start && !busy) begin
            traffic_sb.note_packet(req_dest_addr, req_ip_protocol, req_frame_len);
         end
      end
   end

   task automatic send_packet(input logic [31:0] addr, input logic [7:0] proto,
                              input logic [15:0] flen, input int idle_pct);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(0, 99) < idle_pct) begin
         gap++;
      end
      repeat (gap) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start           <= 1'b1;
      req_dest_addr   <= addr;
      req_ip_protocol <= proto;
      req_frame_len   <= flen;
      @(posedge clock);
      while (busy !== 1'b0) begin
         @(posedge clock);
      end
   endtask

   initial begin
      int          idle_mix [3];
      int          pick;
      logic [31:0] addr;
      logic [7:0]  proto;
      logic [15:0] flen;
      logic [31:0] addr_pool [ADDR_POOL_SIZE];
      logic [31:0] recent [$];

      idle_mix        = '{30, 55, 0};
      reset           = 1'b1;
      start           = 1'b0;
      req_dest_addr   = '0;
      req_ip_protocol = '0;
      req_frame_len   = '0;
      for (int i = 0; i < ADDR_POOL_SIZE; i++) begin
         addr_pool[i] = $urandom();
      end
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Field extremes, each protocol class, and repeated destinations.
      send_packet(32'h0000_0000, PROTO_NUM_TCP, 16'd0, 0);
      send_packet(32'hFFFF_FFFF, PROTO_NUM_UDP, 16'hFFFF, 0);
      send_packet(32'h0000_0000, PROTO_NUM_ICMP, 16'd1, 0);
      send_packet(32'hFFFF_FFFF, 8'd0, 16'd64, 0);
      send_packet(32'hC0A8_0001, 8'hFF, 16'd1500, 0);
      send_packet(32'h0000_0000, PROTO_NUM_TCP, 16'hFFFF, 0);
      send_packet(32'h8000_0000, PROTO_NUM_UDP, 16'h8000, 0);
      send_packet(32'h0000_0001, 8'd2, 16'h7FFF, 0);
      send_packet(32'h7FFF_FFFF, 8'd5, 16'h5555, 0);
      send_packet(32'hAAAA_AAAA, 8'd7, 16'hAAAA, 0);
      send_packet(32'h5555_5555, 8'd16, 16'd40, 0);
      send_packet(32'hAAAA_AAAA, 8'd18, 16'd40, 0);
      send_packet(32'h5555_5555, 8'h80, 16'd576, 0);
      send_packet(32'hC0A8_0001, PROTO_NUM_ICMP, 16'd84, 0);
      send_packet(32'hC0A8_0001, PROTO_NUM_ICMP, 16'd84, 30);
      send_packet(32'h0A00_0001, PROTO_NUM_TCP, 16'd60, 30);

      // Mostly a pool of repeating destinations so that the table fills and
      // known entries keep counting; back-to-back repeats stress the pipeline.
      for (int phase = 0; phase < 3; phase++) begin
         repeat (RANDOM_PER_PHASE) begin
            pick = $urandom_range(0, 99);
            if (pick < 70 || (pick >= 85 && recent.size() == 0)) begin
               addr = addr_pool[$urandom_range(0, ADDR_POOL_SIZE - 1)];
            end else if (pick < 85) begin
               addr = $urandom();
            end else begin
               addr = recent[$urandom_range(0, recent.size() - 1)];
            end
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
               proto = PROTO_NUM_TCP;
            end else if (pick < 55) begin
               proto = PROTO_NUM_UDP;
            end else if (pick < 70) begin
               proto = PROTO_NUM_ICMP;
            end else begin
               proto = 8'($urandom_range(0, 255));
            end
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
               flen = 16'($urandom_range(40, 1500));
            end else if (pick < 60) begin
               flen = (pick < 55) ? 16'd0 : 16'hFFFF;
            end else begin
               flen = 16'($urandom_range(0, 65535));
            end
            send_packet(addr, proto, flen, idle_mix[phase]);
            recent = {recent, addr};
            if (recent.size() > RECENT_DEPTH) begin
               void'(recent.pop_front());
            end
         end
      end
      @(negedge clock);
      start <= 1'b0;

      while (traffic_sb.expected_reports.size() != 0) begin
         @(posedge clock);
      end
      repeat (DTC_DEST_ENTRIES + 16) @(posedge clock);

      $display("Sent %0d packets under three idle mixes: %0d to known destinations,",
               traffic_sb.pkts_seen, traffic_sb.known_hits);
      $display("%0d into new table slots and %0d while the table was full.",
               traffic_sb.new_slots, traffic_sb.table_full_hits);
      if (traffic_sb.errors == 0) begin
         $display("destination_traffic_counter_unit test passed");
      end else begin
         $display("destination_traffic_counter_unit test failed");
      end
      $finish;
   end

endmodule
